@@ rtl/pfm_pkg.sv @@
// ----------------------------------------------------------------------------
// Prime field ALU package
// Shared widths, the field prime, operation codes, controller states and a
// single conditional-subtract helper used by the bit-serial datapath.
// ----------------------------------------------------------------------------
package pfm_pkg;

  // Field widths
  localparam int unsigned RES_W  = 30;
  localparam int unsigned EXP_W  = 63;
  localparam int unsigned KIND_W = 3;

  // Step counter widths for the serial units
  localparam int unsigned MUL_CNT_W = $clog2(RES_W);
  localparam int unsigned RED_CNT_W = $clog2(EXP_W);

  // Field prime and the Fermat inverse exponent M-2
  localparam logic [RES_W-1:0] PRIME_M = 30'd998244353;
  localparam logic [RES_W-1:0] INV_EXP = 30'd998244351;

  // Operation codes
  localparam logic [KIND_W-1:0] KIND_ADD = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SUB = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MUL = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DIV = 3'd3;
  localparam logic [KIND_W-1:0] KIND_POW = 3'd4;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_DISPATCH,
    S_MUL,
    S_POW_CHK,
    S_POW_RUN,
    S_FINISH
  } state_t;

  // Bring a value below 2M into 0..M-1
  function automatic logic [RES_W-1:0] fold_once(input logic [RES_W:0] v);
    logic [RES_W:0] m_ext;
    m_ext = {1'b0, PRIME_M};
    if (v >= m_ext) begin
      return RES_W'(v - m_ext);
    end else begin
      return RES_W'(v);
    end
  endfunction

endpackage

@@ rtl/pfm_if.sv @@
// ----------------------------------------------------------------------------
// Prime field ALU channels
// Request and response channels with a valid/ready handshake and payload.
// ----------------------------------------------------------------------------
interface pfm_req_if;
  logic                          valid;
  logic                          ready;
  logic [pfm_pkg::KIND_W-1:0]    kind;
  logic [pfm_pkg::RES_W-1:0]     operand_a;
  logic [pfm_pkg::EXP_W-1:0]     operand_b;

  modport source (output valid, output kind, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input kind, input operand_a, input operand_b,
                  output ready);
endinterface

interface pfm_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [pfm_pkg::RES_W-1:0]     residue;
  logic                          divide_error;

  modport source (output valid, output residue, output divide_error, input ready);
  modport sink   (input valid, input residue, input divide_error, output ready);
endinterface

@@ rtl/pfm_mulser.sv @@
// ----------------------------------------------------------------------------
// Bit-serial modular multiplier
// Computes x*y mod M, scanning y from its top bit, one bit per cycle.
// ----------------------------------------------------------------------------
module pfm_mulser (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pfm_pkg::RES_W-1:0]   x,
  input  logic [pfm_pkg::RES_W-1:0]   y,
  output logic                        done,
  output logic [pfm_pkg::RES_W-1:0]   product
);

  logic                          busy;
  logic [pfm_pkg::MUL_CNT_W-1:0] cnt;
  logic [pfm_pkg::RES_W-1:0]     xr;
  logic [pfm_pkg::RES_W-1:0]     ysh;
  logic [pfm_pkg::RES_W-1:0]     acc;
  logic [pfm_pkg::RES_W-1:0]     acc_next;
  logic [pfm_pkg::RES_W+1:0]     sum;
  logic [pfm_pkg::RES_W+1:0]     m1;
  logic [pfm_pkg::RES_W+1:0]     m2;

  // Double, add the partial product, fold back below M (sum stays under 3M)
  always_comb begin
    m1  = {2'b00, pfm_pkg::PRIME_M};
    m2  = {1'b0, pfm_pkg::PRIME_M, 1'b0};
    sum = {1'b0, acc, 1'b0} + (ysh[pfm_pkg::RES_W-1] ? {2'b00, xr} : '0);
    priority if (sum >= m2) begin
      acc_next = pfm_pkg::RES_W'(sum - m2);
    end else if (sum >= m1) begin
      acc_next = pfm_pkg::RES_W'(sum - m1);
    end else begin
      acc_next = pfm_pkg::RES_W'(sum);
    end
  end

  // Control: run for RES_W steps, pulse done after the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt  <= cnt + 1'b1;
      busy <= (cnt != pfm_pkg::MUL_CNT_W'(pfm_pkg::RES_W - 1));
      done <= (cnt == pfm_pkg::MUL_CNT_W'(pfm_pkg::RES_W - 1));
    end else begin
      done <= 1'b0;
    end
  end

  // Datapath: load operands, then shift the multiplier out a bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      xr  <= x;
      ysh <= y;
      acc <= '0;
    end else if (busy) begin
      ysh <= {ysh[pfm_pkg::RES_W-2:0], 1'b0};
      acc <= acc_next;
    end
  end

  assign product = acc;

endmodule

@@ rtl/prime_field_mod_alu_unit.sv @@
// ----------------------------------------------------------------------------
// Prime field ALU, modulo 998244353
// Add, subtract, multiply, divide and power over the field, one beat in and
// one beat out per operation.
// ----------------------------------------------------------------------------
// Operation: the unit works on one operation at a time, and a new
// request is taken as soon as the previous one has moved to the output
// register. Add, subtract and multiply start with the bit-serial reduction
// of operand_b; power runs one square-and-multiply step per significant
// exponent bit; divide runs a 30-bit Fermat power and one final multiply.
// The two bit-serial multipliers square and multiply side by side for each
// exponent bit.
// Division by a zero residue returns 0 with divide_error set.
module prime_field_mod_alu_unit (
  input  logic      clk,
  input  logic      rst,
  pfm_req_if.sink   req,
  pfm_rsp_if.source rsp
);

  pfm_pkg::state_t state;
  pfm_pkg::state_t state_next;

  logic [pfm_pkg::KIND_W-1:0]    kind_r;
  logic [pfm_pkg::RES_W-1:0]     a_r;
  logic [pfm_pkg::EXP_W-1:0]     bsh;
  logic [pfm_pkg::RES_W-1:0]     b_r;
  logic [pfm_pkg::RED_CNT_W-1:0] rcnt;
  logic [pfm_pkg::RES_W-1:0]     acc;
  logic [pfm_pkg::RES_W-1:0]     sq;
  logic [pfm_pkg::EXP_W-1:0]     ex;
  logic [pfm_pkg::RES_W-1:0]     res;
  logic                          err;

  logic                          out_valid;
  logic [pfm_pkg::RES_W-1:0]     out_residue;
  logic                          out_error;

  logic                          in_ready;
  logic                          accept;
  logic                          out_load;
  logic                          mul_start;
  logic [pfm_pkg::RES_W-1:0]     mul_x;
  logic [pfm_pkg::RES_W-1:0]     mul_y;
  logic                          sq_start;
  logic                          done1;
  logic                          done2;
  logic [pfm_pkg::RES_W-1:0]     p1;
  logic [pfm_pkg::RES_W-1:0]     p2;
  logic [pfm_pkg::RES_W-1:0]     a_in;
  logic [pfm_pkg::RES_W-1:0]     b_step;
  logic [pfm_pkg::RES_W-1:0]     add_res;
  logic [pfm_pkg::RES_W-1:0]     sub_res;
  logic [pfm_pkg::RES_W:0]       diff;

  // Fold the incoming base, the next bit of the operand_b reduction, add, sub
  always_comb begin
    a_in    = pfm_pkg::fold_once({1'b0, req.operand_a});
    b_step  = pfm_pkg::fold_once({b_r, bsh[pfm_pkg::EXP_W-1]});
    add_res = pfm_pkg::fold_once({1'b0, a_r} + {1'b0, b_r});
    diff    = {1'b0, a_r} - {1'b0, b_r};
    if (diff[pfm_pkg::RES_W]) begin
      sub_res = pfm_pkg::RES_W'(diff + {1'b0, pfm_pkg::PRIME_M});
    end else begin
      sub_res = pfm_pkg::RES_W'(diff);
    end
  end

  assign accept = req.valid && in_ready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      pfm_pkg::S_IDLE: begin
        if (accept) begin
          state_next = (req.kind == pfm_pkg::KIND_POW) ? pfm_pkg::S_POW_CHK
                                                       : pfm_pkg::S_REDUCE;
        end
      end
      pfm_pkg::S_REDUCE: begin
        if (rcnt == pfm_pkg::RED_CNT_W'(pfm_pkg::EXP_W - 1)) begin
          state_next = pfm_pkg::S_DISPATCH;
        end
      end
      pfm_pkg::S_DISPATCH: begin
        if (kind_r == pfm_pkg::KIND_MUL) begin
          state_next = pfm_pkg::S_MUL;
        end else if (kind_r == pfm_pkg::KIND_DIV && b_r != '0) begin
          state_next = pfm_pkg::S_POW_CHK;
        end else begin
          state_next = pfm_pkg::S_FINISH;
        end
      end
      pfm_pkg::S_POW_CHK: begin
        if (ex != '0) begin
          state_next = pfm_pkg::S_POW_RUN;
        end else if (kind_r == pfm_pkg::KIND_DIV) begin
          state_next = pfm_pkg::S_MUL;
        end else begin
          state_next = pfm_pkg::S_FINISH;
        end
      end
      pfm_pkg::S_POW_RUN: begin
        if (done1) begin
          state_next = pfm_pkg::S_POW_CHK;
        end
      end
      pfm_pkg::S_MUL: begin
        if (done1) begin
          state_next = pfm_pkg::S_FINISH;
        end
      end
      pfm_pkg::S_FINISH: begin
        if (out_load) begin
          state_next = pfm_pkg::S_IDLE;
        end
      end
      default: state_next = pfm_pkg::S_IDLE;
    endcase
  end

  // Control outputs and multiplier operand selection
  always_comb begin
    in_ready  = 1'b0;
    out_load  = 1'b0;
    mul_start = 1'b0;
    sq_start  = 1'b0;
    mul_x     = sq;
    mul_y     = acc;
    unique case (state)
      pfm_pkg::S_IDLE: begin
        in_ready = 1'b1;
      end
      pfm_pkg::S_DISPATCH: begin
        mul_x     = a_r;
        mul_y     = b_r;
        mul_start = (kind_r == pfm_pkg::KIND_MUL);
      end
      pfm_pkg::S_POW_CHK: begin
        if (ex != '0) begin
          // Multiply by the current square only where the exponent bit is set
          mul_x     = ex[0] ? sq : pfm_pkg::RES_W'(1);
          mul_y     = acc;
          mul_start = 1'b1;
          sq_start  = 1'b1;
        end else begin
          mul_x     = a_r;
          mul_y     = acc;
          mul_start = (kind_r == pfm_pkg::KIND_DIV);
        end
      end
      pfm_pkg::S_FINISH: begin
        out_load = !out_valid || rsp.ready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pfm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers, advanced by state
  always_ff @(posedge clk) begin
    unique case (state)
      pfm_pkg::S_IDLE: begin
        if (accept) begin
          kind_r <= req.kind;
          a_r    <= a_in;
          bsh    <= req.operand_b;
          b_r    <= '0;
          rcnt   <= '0;
          acc    <= pfm_pkg::RES_W'(1);
          sq     <= a_in;
          ex     <= req.operand_b;
          err    <= 1'b0;
        end
      end
      pfm_pkg::S_REDUCE: begin
        b_r  <= b_step;
        bsh  <= {bsh[pfm_pkg::EXP_W-2:0], 1'b0};
        rcnt <= rcnt + 1'b1;
      end
      pfm_pkg::S_DISPATCH: begin
        priority if (kind_r == pfm_pkg::KIND_ADD) begin
          res <= add_res;
        end else if (kind_r == pfm_pkg::KIND_SUB) begin
          res <= sub_res;
        end else if (kind_r == pfm_pkg::KIND_DIV) begin
          // Divide runs b^(M-2), or flags a zero divisor
          res <= '0;
          acc <= pfm_pkg::RES_W'(1);
          sq  <= b_r;
          ex  <= pfm_pkg::EXP_W'(pfm_pkg::INV_EXP);
          err <= (b_r == '0);
        end else begin
          res <= '0;
        end
      end
      pfm_pkg::S_POW_CHK: begin
        if (ex == '0) begin
          res <= acc;
        end
      end
      pfm_pkg::S_POW_RUN: begin
        if (done1) begin
          acc <= p1;
          sq  <= p2;
          ex  <= ex >> 1;
        end
      end
      pfm_pkg::S_MUL: begin
        if (done1) begin
          res <= p1;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: hold the beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_residue <= res;
      out_error   <= err;
    end
  end

  assign req.ready        = in_ready;
  assign rsp.valid        = out_valid;
  assign rsp.residue      = out_residue;
  assign rsp.divide_error = out_error;

  // Running product and squaring units
  pfm_mulser u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .x       (mul_x),
    .y       (mul_y),
    .done    (done1),
    .product (p1)
  );

  pfm_mulser u_sqr (
    .clk     (clk),
    .rst     (rst),
    .start   (sq_start),
    .x       (sq),
    .y       (sq),
    .done    (done2),
    .product (p2)
  );

  // Checks
  a_res_in_field: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.residue < pfm_pkg::PRIME_M)
    else $error("result residue not reduced");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.divide_error |-> rsp.residue == '0)
    else $error("division error with non-zero residue");

  a_units_lockstep: assert property (@(posedge clk) disable iff (rst)
    state == pfm_pkg::S_POW_RUN |-> done1 == done2)
    else $error("square and multiply units out of step");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> state != pfm_pkg::S_IDLE)
    else $error("request taken but controller stayed idle");

endmodule

@@ sim/tb_prime_field_mod_alu_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prime field ALU testbench
// Drives add, subtract, multiply, divide, power and spare-kind requests into
// the unit and checks every response beat against an in-bench model of
// arithmetic modulo 998244353. Directed corner cases come first, then a long
// output stall that backs the unit up, then randomised traffic in blocks, with
// random gaps on the request or response channel switched per block.
// ----------------------------------------------------------------------------
module tb_prime_field_mod_alu_unit;

  localparam int unsigned RES_W  = pfm_pkg::RES_W;
  localparam int unsigned EXP_W  = pfm_pkg::EXP_W;
  localparam int unsigned KIND_W = pfm_pkg::KIND_W;

  localparam longint unsigned   FIELD_M       = 64'(pfm_pkg::PRIME_M);
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = pfm_pkg::KIND_POW + 3'd1;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = '1;
  localparam logic [RES_W-1:0]  A_ALL_ONES    = '1;
  localparam logic [EXP_W-1:0]  B_ALL_ONES    = '1;
  localparam logic [RES_W-1:0]  A_TOP         = RES_W'(FIELD_M - 1);
  localparam logic [EXP_W-1:0]  B_TOP         = EXP_W'(FIELD_M - 1);
  localparam logic [EXP_W-1:0]  B_FIELD       = EXP_W'(FIELD_M);
  localparam int                MAX_GAP       = 18;
  localparam int                SINK_HOLD     = 400;
  localparam int                TAIL_CYCLES   = 2200;
  localparam int                RANDOM_BLOCKS = 10;
  localparam int                BLOCK_ITEMS   = 100;
  localparam longint            TIMEOUT_NS    = 120_000_000;

  typedef struct packed {
    logic [RES_W-1:0] residue;
    logic             divide_error;
  } field_result_t;

  logic clk;
  logic rst;

  pfm_req_if req_ch ();
  pfm_rsp_if rsp_ch ();

  prime_field_mod_alu_unit i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  field_result_t pending_residues[$];
  int            mismatch_count   = 0;
  bit            src_gaps_on      = 1'b1;
  bit            sink_stalls_on   = 1'b1;
  int            sink_hold_cycles = 0;

  // --------------------------------------------------------------------------
  // Field arithmetic
  // --------------------------------------------------------------------------
  function automatic longint unsigned field_mul(input longint unsigned x,
                                                input longint unsigned y);
    // both below 2^30, so the product stays within 60 bits
    return (x * y) % FIELD_M;
  endfunction

  function automatic longint unsigned field_pow(input longint unsigned base,
                                                input logic [EXP_W-1:0] e);
    longint unsigned acc;
    longint unsigned sq;
    acc = 1;
    sq  = base % FIELD_M;
    for (int i = 0; i < EXP_W; i++) begin
      if (e[i]) begin
        acc = field_mul(acc, sq);
      end
      sq = field_mul(sq, sq);
    end
    return acc;
  endfunction

  function automatic field_result_t field_alu_result(input logic [KIND_W-1:0] kind,
                                                     input logic [RES_W-1:0]  a_raw,
                                                     input logic [EXP_W-1:0]  b_raw);
    longint unsigned a;
    longint unsigned b;
    longint unsigned r;
    logic            err;
    a   = 64'(a_raw) % FIELD_M;
    b   = 64'(b_raw) % FIELD_M;
    r   = 0;
    err = 1'b0;
    case (kind)
      pfm_pkg::KIND_ADD: r = (a + b) % FIELD_M;
      pfm_pkg::KIND_SUB: r = (a + FIELD_M - b) % FIELD_M;
      pfm_pkg::KIND_MUL: r = field_mul(a, b);
      pfm_pkg::KIND_DIV: begin
        // a zero divisor flags the error and returns zero
        if (b == 0) begin
          err = 1'b1;
        end else begin
          r = field_mul(a, field_pow(b, EXP_W'(FIELD_M - 2)));
        end
      end
      pfm_pkg::KIND_POW: r = field_pow(a, b_raw);
      default:  r = 0;
    endcase
    return '{residue: RES_W'(r), divide_error: err};
  endfunction

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Request side: offer one beat after a random gap, hold it until taken
  // --------------------------------------------------------------------------
  task automatic send_op(input logic [KIND_W-1:0] kind,
                         input logic [RES_W-1:0]  a,
                         input logic [EXP_W-1:0]  b);
    int gap;
    gap = src_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_ch.valid     <= 1'b1;
    req_ch.kind      <= kind;
    req_ch.operand_a <= a;
    req_ch.operand_b <= b;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    pending_residues.insert(pending_residues.size(), field_alu_result(kind, a, b));
  endtask

  // Drop valid and wait until every response has been seen
  task automatic wait_all_results();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_residues.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Response side: stall at random, check each beat against the oldest entry
  // --------------------------------------------------------------------------
  initial begin
    int            stall;
    field_result_t want;
    stall        = 0;
    rsp_ch.ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      @(negedge clk);
      if (sink_hold_cycles > 0) begin
        rsp_ch.ready <= 1'b0;
        sink_hold_cycles--;
      end else if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        stall--;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
      @(posedge clk);
      if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
        if (pending_residues.size() == 0) begin
          $display("%0t: unexpected response beat residue=%0d divide_error=%0b",
                   $time, rsp_ch.residue, rsp_ch.divide_error);
          mismatch_count++;
        end else begin
          want = pending_residues.pop_front();
          if (rsp_ch.residue !== want.residue) begin
            $display("%0t: residue mismatch expected=%0d actual=%0d",
                     $time, want.residue, rsp_ch.residue);
            mismatch_count++;
          end
          if (rsp_ch.divide_error !== want.divide_error) begin
            $display("%0t: divide_error mismatch expected=%0b actual=%0b",
                     $time, want.divide_error, rsp_ch.divide_error);
            mismatch_count++;
          end
        end
        stall = sink_stalls_on ? $urandom_range(0, MAX_GAP) : 0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Field extremes, every kind, zero divisors, zero exponents, wide bases
  task automatic test_directed();
    send_op(pfm_pkg::KIND_ADD, A_TOP, B_TOP);
    send_op(pfm_pkg::KIND_ADD, A_ALL_ONES, B_ALL_ONES);
    send_op(pfm_pkg::KIND_SUB, '0, B_TOP);
    send_op(pfm_pkg::KIND_SUB, 30'd5, 63'd5);
    send_op(pfm_pkg::KIND_SUB, A_ALL_ONES, '0);
    send_op(pfm_pkg::KIND_MUL, A_TOP, B_TOP);
    send_op(pfm_pkg::KIND_MUL, A_ALL_ONES, B_ALL_ONES);
    send_op(pfm_pkg::KIND_MUL, '0, B_ALL_ONES);
    send_op(pfm_pkg::KIND_DIV, 30'd1, '0);
    send_op(pfm_pkg::KIND_DIV, A_TOP, B_FIELD);
    send_op(pfm_pkg::KIND_DIV, 30'd7, EXP_W'(FIELD_M * 3));
    send_op(pfm_pkg::KIND_DIV, 30'd1, 63'd2);
    send_op(pfm_pkg::KIND_DIV, '0, B_TOP);
    send_op(pfm_pkg::KIND_DIV, A_ALL_ONES, B_ALL_ONES);
    send_op(pfm_pkg::KIND_POW, '0, '0);
    send_op(pfm_pkg::KIND_POW, 30'd12345, '0);
    send_op(pfm_pkg::KIND_POW, '0, 63'd5);
    send_op(pfm_pkg::KIND_POW, 30'd3, 63'd1);
    send_op(pfm_pkg::KIND_POW, 30'd3, B_TOP);
    send_op(pfm_pkg::KIND_POW, A_TOP, 63'd2);
    send_op(pfm_pkg::KIND_POW, A_ALL_ONES, B_ALL_ONES);
    for (int k = KIND_SPARE_LO; k <= KIND_SPARE_HI; k++) begin
      send_op(KIND_W'(k), A_ALL_ONES, B_ALL_ONES);
    end
    wait_all_results();
  endtask

  // Hold the response side off while requests keep coming, so input stalls
  task automatic test_backpressure();
    @(posedge clk);
    sink_hold_cycles = SINK_HOLD;
    src_gaps_on      = 1'b0;
    for (int i = 0; i < 12; i++) begin
      send_op(pfm_pkg::KIND_MUL, RES_W'($urandom), EXP_W'({$urandom, $urandom}));
    end
    src_gaps_on = 1'b1;
    wait_all_results();
  endtask

  // Random traffic in blocks, each block with its own idling pattern
  task automatic test_random();
    int                pick;
    int                w;
    logic [KIND_W-1:0] k;
    logic [RES_W-1:0]  a;
    logic [EXP_W-1:0]  b;
    for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      src_gaps_on    = (blk % 4) >= 2;
      sink_stalls_on = (blk % 4) == 1 || (blk % 4) == 3;
      for (int i = 0; i < BLOCK_ITEMS; i++) begin
        // pick the operation
        pick = $urandom_range(0, 99);
        if (pick < 20)      k = pfm_pkg::KIND_ADD;
        else if (pick < 40) k = pfm_pkg::KIND_SUB;
        else if (pick < 60) k = pfm_pkg::KIND_MUL;
        else if (pick < 70) k = pfm_pkg::KIND_DIV;
        else if (pick < 95) k = pfm_pkg::KIND_POW;
        else                k = KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));

        // base: mostly in range, some wide, some at the edges
        pick = $urandom_range(0, 99);
        if (pick < 80)      a = RES_W'($urandom_range(0, FIELD_M - 1));
        else if (pick < 93) a = RES_W'($urandom);
        else if (pick < 96) a = '0;
        else                a = A_TOP;

        // second operand: keep power exponents short, bar a few full ones
        pick = $urandom_range(0, 99);
        if (k == pfm_pkg::KIND_POW) begin
          if (pick < 3) begin
            b = EXP_W'({$urandom, $urandom});
          end else begin
            w = $urandom_range(0, 16);
            b = EXP_W'($urandom) & EXP_W'((64'd1 << w) - 1);
          end
        end else if (k == pfm_pkg::KIND_DIV && pick < 8) begin
          b = EXP_W'(FIELD_M * 64'($urandom));
        end else if (pick < 15) begin
          b = EXP_W'($urandom_range(0, FIELD_M - 1));
        end else begin
          b = EXP_W'({$urandom, $urandom});
        end
        send_op(k, a, b);
      end
      wait_all_results();
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst              = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.kind      = '0;
    req_ch.operand_a = '0;
    req_ch.operand_b = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_backpressure();
    test_random();

    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Bound the run
  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timeout with %0d responses outstanding",
             $time, pending_residues.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
